// ===== rtl/b3h_pkg.sv =====
// Package with the BLAKE3 constants, types and mixing functions.
`default_nettype none
package b3h_pkg;
  typedef logic [31:0] word_t;
  typedef word_t [15:0] vec_t;
  typedef logic [2:0] rnd_t;

  localparam int unsigned Rounds = 7;
  localparam logic [6:0] MaxLen = 7'd64;
  localparam word_t RootFlags = 32'd11;

  localparam word_t [7:0] Iv = '{
    32'h5BE0CD19, 32'h1F83D9AB, 32'h9B05688C, 32'h510E527F,
    32'hA54FF53A, 32'h3C6EF372, 32'hBB67AE85, 32'h6A09E667};

  localparam logic [3:0] Perm [16] = '{
    4'd2, 4'd6, 4'd3, 4'd10, 4'd7, 4'd0, 4'd4, 4'd13,
    4'd1, 4'd11, 4'd12, 4'd5, 4'd9, 4'd14, 4'd15, 4'd8};

  function automatic word_t ror(input word_t x, input int unsigned n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

  function automatic vec_t mix(input vec_t v, input int unsigned a, input int unsigned b,
                               input int unsigned c, input int unsigned d,
                               input word_t x, input word_t y);
    vec_t r;
    r = v;
    r[a] = r[a] + r[b] + x;
    r[d] = ror(r[d] ^ r[a], 16);
    r[c] = r[c] + r[d];
    r[b] = ror(r[b] ^ r[c], 12);
    r[a] = r[a] + r[b] + y;
    r[d] = ror(r[d] ^ r[a], 8);
    r[c] = r[c] + r[d];
    r[b] = ror(r[b] ^ r[c], 7);
    mix = r;
  endfunction

  function automatic vec_t permute(input vec_t w);
    vec_t t;
    for (int i = 0; i < 16; i++) t[i] = w[Perm[i]];
    permute = t;
  endfunction
endpackage
`default_nettype wire

// ===== rtl/b3h_if.sv =====
// Valid/ready channel interfaces for message blocks and digests.
`default_nettype none
interface b3h_in_if;
  logic valid;
  logic ready;
  logic [63:0] block_w0, block_w1, block_w2, block_w3;
  logic [63:0] block_w4, block_w5, block_w6, block_w7;
  logic [6:0] length;
  modport source(output valid, block_w0, block_w1, block_w2, block_w3,
                 block_w4, block_w5, block_w6, block_w7, length, input ready);
  modport sink(input valid, block_w0, block_w1, block_w2, block_w3,
               block_w4, block_w5, block_w6, block_w7, length, output ready);
endinterface

interface b3h_out_if;
  logic valid;
  logic ready;
  logic [63:0] digest_q0, digest_q1, digest_q2, digest_q3;
  modport source(output valid, digest_q0, digest_q1, digest_q2, digest_q3, input ready);
  modport sink(input valid, digest_q0, digest_q1, digest_q2, digest_q3, output ready);
endinterface
`default_nettype wire

// ===== rtl/b3h_round.sv =====
// One registered BLAKE3 round stage with its message schedule.
`default_nettype none
module b3h_round #(
  parameter bit DoPerm = 1'b1
) (
  input  wire             clk,
  input  wire             rst,
  input  wire             en,
  input  wire             valid_in,
  input  b3h_pkg::vec_t   v_in,
  input  b3h_pkg::vec_t   w_in,
  output logic            valid,
  output b3h_pkg::vec_t   v,
  output b3h_pkg::vec_t   w
);
  b3h_pkg::vec_t v_next;

  always_comb begin
    v_next = v_in;
    v_next = b3h_pkg::mix(v_next, 0, 4, 8, 12, w_in[0], w_in[1]);
    v_next = b3h_pkg::mix(v_next, 1, 5, 9, 13, w_in[2], w_in[3]);
    v_next = b3h_pkg::mix(v_next, 2, 6, 10, 14, w_in[4], w_in[5]);
    v_next = b3h_pkg::mix(v_next, 3, 7, 11, 15, w_in[6], w_in[7]);
    v_next = b3h_pkg::mix(v_next, 0, 5, 10, 15, w_in[8], w_in[9]);
    v_next = b3h_pkg::mix(v_next, 1, 6, 11, 12, w_in[10], w_in[11]);
    v_next = b3h_pkg::mix(v_next, 2, 7, 8, 13, w_in[12], w_in[13]);
    v_next = b3h_pkg::mix(v_next, 3, 4, 9, 14, w_in[14], w_in[15]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid_in;
    end
    if (en) begin
      v <= v_next;
      w <= DoPerm ? b3h_pkg::permute(w_in) : w_in;
    end
  end

  assert property (@(posedge clk) disable iff (rst) !en |=> $stable(v) && $stable(valid))
    else $error("round stage changed while stalled");
endmodule
`default_nettype wire

// ===== rtl/blake3_single_block_hash.sv =====
// Top level: fully unrolled BLAKE3 single-block root hash pipeline.
//
// The block hashes one message of 0 to 64 bytes per transaction. The sink
// channel msg carries eight 64-bit little-endian words and the byte length;
// bytes at or past the length are cleared before hashing. The source channel
// dig carries the 256-bit digest as four 64-bit little-endian words.
// The pipeline has nine register stages: an input stage that masks the block
// and builds the initial state, seven round stages (one round of eight G
// mixes each), and an output stage that folds the state halves together.
// An accepted transaction passes from the input stage through the round stages
// to the output stage before its digest is valid. One transaction is
// accepted every cycle while the output moves.
// A stage moves when it or any stage after it is empty, or when the output
// register is being taken, so a stalled receiver freezes the occupied stages
// and nothing is lost or repeated. Bubbles ahead of the stall still fill in.
// Reset clears every valid bit; data registers are not reset.
`default_nettype none
module blake3_single_block_hash (
  input wire clk,
  input wire rst,
  b3h_in_if.sink    msg,
  b3h_out_if.source dig
);
  localparam int unsigned Stages = b3h_pkg::Rounds + 2;

  // Per-stage valid and advance enables; stage 0 is the input register,
  // stage Stages-1 the output register.
  logic [Stages-1:0] sv;
  logic [Stages-1:0] adv;
  b3h_pkg::vec_t vs [Stages-1];
  b3h_pkg::vec_t ws [Stages-1];

  // A stage may load when it is empty or the stage after it also loads.
  always_comb begin
    adv[Stages-1] = !sv[Stages-1] || dig.ready;
    for (int i = Stages - 2; i >= 0; i--) adv[i] = !sv[i] || adv[i+1];
  end

  assign msg.ready = adv[0];

  // Input stage: length clamp, byte mask and initial state.
  logic [6:0] len;
  logic [511:0] blk, mask;
  b3h_pkg::vec_t w0, v0;
  always_comb begin
    len = (msg.length > b3h_pkg::MaxLen) ? b3h_pkg::MaxLen : msg.length;
    blk = {msg.block_w7, msg.block_w6, msg.block_w5, msg.block_w4,
           msg.block_w3, msg.block_w2, msg.block_w1, msg.block_w0};
    for (int i = 0; i < 64; i++) mask[8*i +: 8] = (7'(i) < len) ? 8'hFF : 8'h00;
    w0 = b3h_pkg::vec_t'(blk & mask);
    for (int i = 0; i < 8; i++) v0[i] = b3h_pkg::Iv[i];
    for (int i = 0; i < 4; i++) v0[8+i] = b3h_pkg::Iv[i];
    v0[12] = '0;
    v0[13] = '0;
    v0[14] = {25'd0, len};
    v0[15] = b3h_pkg::RootFlags;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else if (adv[0]) begin
      sv[0] <= msg.valid;
    end
    if (adv[0]) begin
      vs[0] <= v0;
      ws[0] <= w0;
    end
  end

  // Seven round stages; the final one needs no message permutation.
  for (genvar r = 0; r < b3h_pkg::Rounds; r++) begin : g_round
    b3h_round #(.DoPerm(r + 1 < b3h_pkg::Rounds)) u_round (
      .clk(clk), .rst(rst), .en(adv[r+1]), .valid_in(sv[r]),
      .v_in(vs[r]), .w_in(ws[r]),
      .valid(sv[r+1]), .v(vs[r+1]), .w(ws[r+1]));
  end

  // Output stage: XOR of the two state halves.
  logic [255:0] dq;
  always_ff @(posedge clk) begin
    if (rst) begin
      sv[Stages-1] <= 1'b0;
    end else if (adv[Stages-1]) begin
      sv[Stages-1] <= sv[Stages-2];
    end
    if (adv[Stages-1]) begin
      for (int i = 0; i < 8; i++)
        dq[32*i +: 32] <= vs[Stages-2][i] ^ vs[Stages-2][i+8];
    end
  end

  assign dig.valid     = sv[Stages-1];
  assign dig.digest_q0 = dq[63:0];
  assign dig.digest_q1 = dq[127:64];
  assign dig.digest_q2 = dq[191:128];
  assign dig.digest_q3 = dq[255:192];

  assert property (@(posedge clk) disable iff (rst)
    dig.valid && !dig.ready |=> dig.valid && $stable(dq))
    else $error("digest dropped or changed under stall");
  assert property (@(posedge clk) disable iff (rst)
    msg.valid && msg.ready |=> sv[0])
    else $error("accepted transaction not captured");
  assert property (@(posedge clk) disable iff (rst)
    sv[Stages-2] && !adv[Stages-1] |=> sv[Stages-2])
    else $error("last round result lost during stall");
endmodule
`default_nettype wire
